[hdl/fbpa_pkg.sv]
// Shared constants, codes and control types for the fixed block pool allocator.
package fbpa_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int HDR_W    = 4;
    localparam int STATUS_W = 3;
    localparam int CLS_W    = 2;

    // Default pool layout
    localparam int CLASS0_BYTES  = 16;
    localparam int CLASS1_BYTES  = 32;
    localparam int CLASS2_BYTES  = 64;
    localparam int CLASS0_BLOCKS = 8;
    localparam int CLASS1_BLOCKS = 8;
    localparam int CLASS2_BLOCKS = 4;

    // Register reset values
    localparam logic [ADDR_W-1:0] AREA_BASE_RST    = '0;
    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

    // Request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Size class codes
    localparam logic [CLS_W-1:0] CLS0 = 2'd0;
    localparam logic [CLS_W-1:0] CLS1 = 2'd1;
    localparam logic [CLS_W-1:0] CLS2 = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 1'b1;

    // Decoded request handed to the pool state
    typedef struct packed {
        logic             valid;
        logic             is_free;
        logic             hit;
        logic [CLS_W-1:0] cls;
    } fbpa_ctl_t;

endpackage

[hdl/fbpa_layout.sv]
// Pool layout: size class selection, free address decode and block offset lookup.
module fbpa_layout #(
    parameter int CLASS0_BYTES  = fbpa_pkg::CLASS0_BYTES,
    parameter int CLASS1_BYTES  = fbpa_pkg::CLASS1_BYTES,
    parameter int CLASS2_BYTES  = fbpa_pkg::CLASS2_BYTES,
    parameter int CLASS0_BLOCKS = fbpa_pkg::CLASS0_BLOCKS,
    parameter int CLASS1_BLOCKS = fbpa_pkg::CLASS1_BLOCKS,
    parameter int CLASS2_BLOCKS = fbpa_pkg::CLASS2_BLOCKS,
    parameter int IDX_W         = 5,
    parameter int ABITS         = 5
) (
    input  logic                          req_type,
    input  logic [fbpa_pkg::SIZE_W-1:0]   req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]   user_addr,
    input  logic [fbpa_pkg::ADDR_W-1:0]   area_base,
    input  logic [fbpa_pkg::HDR_W-1:0]    header_bytes,
    input  logic [IDX_W-1:0]              pop_idx,
    output logic                          hit,
    output logic [fbpa_pkg::CLS_W-1:0]    cls,
    output logic [IDX_W-1:0]              free_idx,
    output logic [fbpa_pkg::ADDR_W-1:0]   pop_off
);

    localparam int FIRST1 = CLASS0_BLOCKS;
    localparam int FIRST2 = CLASS0_BLOCKS + CLASS1_BLOCKS;
    localparam int TOTAL  = FIRST2 + CLASS2_BLOCKS;
    localparam int OFF1   = CLASS0_BYTES * CLASS0_BLOCKS;
    localparam int OFF2   = OFF1 + CLASS1_BYTES * CLASS1_BLOCKS;
    localparam int CMP_W  = fbpa_pkg::SIZE_W + 1;

    logic [fbpa_pkg::ADDR_W-1:0] blk_off [TOTAL];
    logic [fbpa_pkg::CLS_W-1:0]  blk_cls [TOTAL];
    logic [TOTAL-1:0]            match;
    logic [fbpa_pkg::ADDR_W-1:0] off;
    logic [fbpa_pkg::CLS_W-1:0]  free_cls;
    logic [fbpa_pkg::CLS_W-1:0]  alloc_cls;
    logic                        fit0;
    logic                        fit1;
    logic                        fit2;

    // Offset of the header start from the pool base
    assign off = user_addr - fbpa_pkg::ADDR_W'(header_bytes) - area_base;

    // Per-block constant offsets and class codes, compared against the free address
    for (genvar b = 0; b < TOTAL; b++) begin : g_blk
        localparam int BO = (b < FIRST1) ? b * CLASS0_BYTES :
                            (b < FIRST2) ? OFF1 + (b - FIRST1) * CLASS1_BYTES :
                                           OFF2 + (b - FIRST2) * CLASS2_BYTES;
        assign blk_off[b] = fbpa_pkg::ADDR_W'(BO);
        assign blk_cls[b] = (b < FIRST1) ? fbpa_pkg::CLS0 :
                            (b < FIRST2) ? fbpa_pkg::CLS1 : fbpa_pkg::CLS2;
        assign match[b]   = (off == blk_off[b]);
    end

    // Encode the one-hot block match into index and class
    always_comb
    begin
        free_idx = '0;
        free_cls = '0;
        for (int b = 0; b < TOTAL; b++)
        begin
            if (match[b])
            begin
                free_idx = free_idx | IDX_W'(b);
                free_cls = free_cls | blk_cls[b];
            end
        end
    end

    // Pick the first class whose payload holds the request
    assign fit0 = CMP_W'(req_size) <= (CMP_W'(CLASS0_BYTES) - CMP_W'(header_bytes));
    assign fit1 = CMP_W'(req_size) <= (CMP_W'(CLASS1_BYTES) - CMP_W'(header_bytes));
    assign fit2 = CMP_W'(req_size) <= (CMP_W'(CLASS2_BYTES) - CMP_W'(header_bytes));

    always_comb
    begin
        priority if (fit0)
            alloc_cls = fbpa_pkg::CLS0;
        else if (fit1)
            alloc_cls = fbpa_pkg::CLS1;
        else
            alloc_cls = fbpa_pkg::CLS2;
    end

    assign hit = (req_type == fbpa_pkg::REQ_FREE) ? |match : (fit0 | fit1 | fit2);
    assign cls = (req_type == fbpa_pkg::REQ_FREE) ? free_cls : alloc_cls;

    // Look up the popped block's offset; the null code reads as zero
    assign pop_off = (32'(pop_idx) < 32'(TOTAL)) ? blk_off[pop_idx[ABITS-1:0]] : '0;

endmodule

[hdl/fbpa_pool.sv]
// Free list state: per-class list heads, link table and allocation flags.
module fbpa_pool #(
    parameter int CLASS0_BLOCKS = fbpa_pkg::CLASS0_BLOCKS,
    parameter int CLASS1_BLOCKS = fbpa_pkg::CLASS1_BLOCKS,
    parameter int CLASS2_BLOCKS = fbpa_pkg::CLASS2_BLOCKS,
    parameter int IDX_W         = 5,
    parameter int ABITS         = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fbpa_pkg::fbpa_ctl_t            ctl,
    input  logic [IDX_W-1:0]               free_idx,
    output logic [fbpa_pkg::STATUS_W-1:0]  status,
    output logic [IDX_W-1:0]               pop_idx
);

    localparam int FIRST1 = CLASS0_BLOCKS;
    localparam int FIRST2 = CLASS0_BLOCKS + CLASS1_BLOCKS;
    localparam int TOTAL  = FIRST2 + CLASS2_BLOCKS;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(TOTAL);

    logic [IDX_W-1:0] heads_reg [3];
    logic [IDX_W-1:0] link_reg [TOTAL];
    logic [TOTAL-1:0] used_reg;
    logic [IDX_W-1:0] cur_head;
    logic [ABITS-1:0] head_a;
    logic [ABITS-1:0] free_a;
    logic             pop_ok;
    logic             push_ok;

    // Select the head of the addressed class
    always_comb
    begin
        priority if (ctl.cls == fbpa_pkg::CLS1)
            cur_head = heads_reg[1];
        else if (ctl.cls == fbpa_pkg::CLS2)
            cur_head = heads_reg[2];
        else
            cur_head = heads_reg[0];
    end

    assign head_a  = cur_head[ABITS-1:0];
    assign free_a  = free_idx[ABITS-1:0];
    assign pop_idx = cur_head;

    // Resolve the request status and which list operation it performs
    always_comb
    begin
        pop_ok  = 1'b0;
        push_ok = 1'b0;
        if (!ctl.is_free)
        begin
            priority if (!ctl.hit)
                status = fbpa_pkg::ST_TOO_LARGE;
            else if (cur_head == NULL_IDX)
                status = fbpa_pkg::ST_EXHAUSTED;
            else
            begin
                status = fbpa_pkg::ST_OK;
                pop_ok = ctl.valid;
            end
        end
        else
        begin
            priority if (!ctl.hit)
                status = fbpa_pkg::ST_BAD_ADDR;
            else if (!used_reg[free_a])
                status = fbpa_pkg::ST_NOT_ALLOC;
            else
            begin
                status  = fbpa_pkg::ST_OK;
                push_ok = ctl.valid;
            end
        end
    end

    // Pop from or push onto the class list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_reg[0] <= '0;
            heads_reg[1] <= IDX_W'(FIRST1);
            heads_reg[2] <= IDX_W'(FIRST2);
            used_reg     <= '0;
            for (int b = 0; b < TOTAL; b++)
            begin
                if (b == FIRST1 - 1 || b == FIRST2 - 1 || b == TOTAL - 1)
                    link_reg[b] <= NULL_IDX;
                else
                    link_reg[b] <= IDX_W'(b + 1);
            end
        end
        else
        begin
            if (pop_ok)
            begin
                heads_reg[ctl.cls] <= link_reg[head_a];
                used_reg[head_a]   <= 1'b1;
            end
            if (push_ok)
            begin
                link_reg[free_a]   <= cur_head;
                heads_reg[ctl.cls] <= free_idx;
                used_reg[free_a]   <= 1'b0;
            end
        end
    end

endmodule

[hdl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: registers, request and result stages.
//
// Each request enters on a cycle with start high and busy low (busy stays low, so a
// request can enter every cycle). The request is registered, resolved against the
// free lists in the following cycle, and its result is then captured in the result
// register and appears with done high for one cycle; throughput is one request per
// cycle, set by the single compute stage between the request register and the
// result register. Results cannot be held off: the receiver must take each one in
// its done cycle. Configuration writes take effect at once and belong in idle
// periods only.
module fixed_block_pool_allocator #(
    parameter int CLASS0_BYTES  = fbpa_pkg::CLASS0_BYTES,
    parameter int CLASS1_BYTES  = fbpa_pkg::CLASS1_BYTES,
    parameter int CLASS2_BYTES  = fbpa_pkg::CLASS2_BYTES,
    parameter int CLASS0_BLOCKS = fbpa_pkg::CLASS0_BLOCKS,
    parameter int CLASS1_BLOCKS = fbpa_pkg::CLASS1_BLOCKS,
    parameter int CLASS2_BLOCKS = fbpa_pkg::CLASS2_BLOCKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [fbpa_pkg::ADDR_W-1:0]       cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [fbpa_pkg::SIZE_W-1:0]       req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]       user_addr,
    output logic                              done,
    output logic [fbpa_pkg::STATUS_W-1:0]     status,
    output logic [fbpa_pkg::ADDR_W-1:0]       payload_addr
);

    localparam int TOTAL = CLASS0_BLOCKS + CLASS1_BLOCKS + CLASS2_BLOCKS;
    localparam int IDX_W = $clog2(TOTAL + 1);
    localparam int ABITS = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    logic [fbpa_pkg::ADDR_W-1:0]   area_base_reg;
    logic [fbpa_pkg::HDR_W-1:0]    header_bytes_reg;
    logic                          in_valid_reg;
    logic                          req_type_reg;
    logic [fbpa_pkg::SIZE_W-1:0]   req_size_reg;
    logic [fbpa_pkg::ADDR_W-1:0]   user_addr_reg;
    logic                          done_reg;
    logic [fbpa_pkg::STATUS_W-1:0] status_reg;
    logic [fbpa_pkg::ADDR_W-1:0]   payload_reg;
    logic [fbpa_pkg::ADDR_W-1:0]   payload_next;
    logic                          accept;
    fbpa_pkg::fbpa_ctl_t           ctl;
    logic                          hit;
    logic [fbpa_pkg::CLS_W-1:0]    cls;
    logic [IDX_W-1:0]              free_idx;
    logic [IDX_W-1:0]              pop_idx;
    logic [fbpa_pkg::ADDR_W-1:0]   pop_off;
    logic [fbpa_pkg::STATUS_W-1:0] pool_status;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_base_reg    <= fbpa_pkg::AREA_BASE_RST;
            header_bytes_reg <= fbpa_pkg::HEADER_BYTES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx)
                fbpa_pkg::REG_AREA_BASE:    area_base_reg    <= cfg_wdata;
                fbpa_pkg::REG_HEADER_BYTES: header_bytes_reg <= cfg_wdata[fbpa_pkg::HDR_W-1:0];
                default:                    area_base_reg    <= area_base_reg;
            endcase
        end
    end

    // Capture the request on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req_type;
            req_size_reg  <= req_size;
            user_addr_reg <= user_addr;
        end
    end

    fbpa_layout #(
        .CLASS0_BYTES  (CLASS0_BYTES),
        .CLASS1_BYTES  (CLASS1_BYTES),
        .CLASS2_BYTES  (CLASS2_BYTES),
        .CLASS0_BLOCKS (CLASS0_BLOCKS),
        .CLASS1_BLOCKS (CLASS1_BLOCKS),
        .CLASS2_BLOCKS (CLASS2_BLOCKS),
        .IDX_W         (IDX_W),
        .ABITS         (ABITS)
    ) u_layout (
        .req_type     (req_type_reg),
        .req_size     (req_size_reg),
        .user_addr    (user_addr_reg),
        .area_base    (area_base_reg),
        .header_bytes (header_bytes_reg),
        .pop_idx      (pop_idx),
        .hit          (hit),
        .cls          (cls),
        .free_idx     (free_idx),
        .pop_off      (pop_off)
    );

    assign ctl.valid   = in_valid_reg;
    assign ctl.is_free = (req_type_reg == fbpa_pkg::REQ_FREE);
    assign ctl.hit     = hit;
    assign ctl.cls     = cls;

    fbpa_pool #(
        .CLASS0_BLOCKS (CLASS0_BLOCKS),
        .CLASS1_BLOCKS (CLASS1_BLOCKS),
        .CLASS2_BLOCKS (CLASS2_BLOCKS),
        .IDX_W         (IDX_W),
        .ABITS         (ABITS)
    ) u_pool (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .free_idx (free_idx),
        .status   (pool_status),
        .pop_idx  (pop_idx)
    );

    // Payload address only on a good allocate
    assign payload_next = (!ctl.is_free && pool_status == fbpa_pkg::ST_OK)
                        ? area_base_reg + pop_off + fbpa_pkg::ADDR_W'(header_bytes_reg)
                        : '0;

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            status_reg  <= pool_status;
            payload_reg <= payload_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign payload_addr = payload_reg;

endmodule

[hdl/fbpa_checker.sv]
// Port-level checks for the fixed block pool allocator, bound to the top level.
module fbpa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [fbpa_pkg::STATUS_W-1:0]     status,
    input logic [fbpa_pkg::ADDR_W-1:0]       payload_addr
);

    // Every transfer yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request transfer without a result two cycles later");

    // No result without an earlier matching transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching request");

    // Status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == fbpa_pkg::ST_OK || status == fbpa_pkg::ST_TOO_LARGE ||
                  status == fbpa_pkg::ST_EXHAUSTED || status == fbpa_pkg::ST_BAD_ADDR ||
                  status == fbpa_pkg::ST_NOT_ALLOC))
        else $error("undefined status code");

    // Errors carry a zero payload address
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != fbpa_pkg::ST_OK) |-> (payload_addr == '0))
        else $error("nonzero payload address on error");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .payload_addr (payload_addr)
);
